@@ hdl/emee_pkg.sv @@
package emee_pkg;

    localparam int ACTION_W  = 2;
    localparam int CFG_IDX_W = 2;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_DERIVE  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ENCRYPT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DECRYPT = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GENERATOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRIVATE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PEER      = 2'd3;

endpackage

@@ hdl/emee_if.sv @@
interface emee_in_if #(
    parameter int WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic [emee_pkg::ACTION_W-1:0] action;
    logic [WIDTH-1:0]              message;
    logic [WIDTH-1:0]              ephemeral_exponent;
    logic [WIDTH-1:0]              cipher_first;
    logic [WIDTH-1:0]              cipher_second;

    modport source (
        output valid, action, message, ephemeral_exponent, cipher_first, cipher_second,
        input  ready
    );
    modport sink (
        input  valid, action, message, ephemeral_exponent, cipher_first, cipher_second,
        output ready
    );
endinterface

interface emee_out_if #(
    parameter int WIDTH = 32
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] first_value;
    logic [WIDTH-1:0] second_value;

    modport source (
        output valid, first_value, second_value,
        input  ready
    );
    modport sink (
        input  valid, first_value, second_value,
        output ready
    );
endinterface

interface emee_cfg_if #(
    parameter int WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic [emee_pkg::CFG_IDX_W-1:0] index;
    logic [WIDTH-1:0]               data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

@@ hdl/elgamal_modexp_engine_unit.sv @@
// ElGamal engine: derive public key, encrypt, decrypt over a prime modulus.
// Channels:
//   i_cfg : register writes (modulus, generator, private key, peer public key),
//           always ready; write only while no request is in flight.
//   i_in  : one request word (action and operands); ready only when idle.
//   o_out : one result word per request (first_value, second_value).
// Every product runs through one shared modular multiplier that retires one
// multiplier bit per cycle. Exponentiation is right-to-left
// square-and-multiply, up to 2 products per exponent bit. Zero modulus or
// the unused action code answers zeros without using the multiplier. One
// request at a time.
// The result sits in an output register; while the receiver stalls the next
// request is still taken and computed, and then waits for the register.
// Reset: config returns to modulus 3, generator 2, private key 1, peer key 1;
// any request in flight and any pending result are dropped.
module elgamal_modexp_engine_unit #(
    parameter int WIDTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    emee_cfg_if.sink        i_cfg,
    emee_in_if.sink         i_in,
    emee_out_if.source      o_out
);

    localparam int CNT_W = $clog2(WIDTH);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_SQ_INIT  = 9'b000000010,
        S_POW_NEXT = 9'b000000100,
        S_POW_MUL  = 9'b000001000,
        S_POW_SQR  = 9'b000010000,
        S_POW_END  = 9'b000100000,
        S_FIN_RED  = 9'b001000000,
        S_FIN_MUL  = 9'b010000000,
        S_DONE     = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [WIDTH-1:0] r_m, r_g, r_priv, r_peer;
    logic [emee_pkg::ACTION_W-1:0] r_act, n_act;
    logic             r_phase, n_phase;
    logic [WIDTH-1:0] r_msg, n_msg, r_k, n_k, r_ce, n_ce;
    logic [WIDTH-1:0] r_exp, n_exp, r_acc, n_acc, r_sq, n_sq;
    logic [WIDTH-1:0] r_p, n_p, r_a, n_a, r_b, n_b;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [WIDTH-1:0] r_first, n_first, r_second, n_second;
    logic             r_ovalid, n_ovalid;
    logic [WIDTH-1:0] r_ofirst, n_ofirst, r_osecond, n_osecond;

    logic             in_acc;
    logic             mul_active, mul_done;
    logic [WIDTH-1:0] one_m, dec_exp;
    logic [WIDTH:0]   mw, p2, p2_sub, s, s_sub;
    logic [WIDTH-1:0] d, mul_res;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;

    assign o_out.valid        = r_ovalid;
    assign o_out.first_value  = r_ofirst;
    assign o_out.second_value = r_osecond;

    // 1 mod m: zero only when m is one
    assign one_m   = {{(WIDTH-1){1'b0}}, (r_m != {{(WIDTH-1){1'b0}}, 1'b1})};
    assign dec_exp = r_m - {{(WIDTH-1){1'b0}}, 1'b1} - r_priv;

    // one multiplier bit: p = 2p mod m, then p = p + a mod m if the bit is set
    assign mw      = {1'b0, r_m};
    assign p2      = {r_p, 1'b0};
    assign p2_sub  = p2 - mw;
    assign d       = (p2 >= mw) ? p2_sub[WIDTH-1:0] : p2[WIDTH-1:0];
    assign s       = {1'b0, d} + {1'b0, r_a};
    assign s_sub   = s - mw;
    assign mul_res = r_b[WIDTH-1] ? ((s >= mw) ? s_sub[WIDTH-1:0] : s[WIDTH-1:0]) : d;

    assign mul_active = (r_state == S_SQ_INIT) || (r_state == S_POW_MUL) ||
                        (r_state == S_POW_SQR) || (r_state == S_FIN_RED) ||
                        (r_state == S_FIN_MUL);
    assign mul_done   = mul_active && (r_cnt == CNT_W'(WIDTH - 1));

    always_comb begin
        n_state   = r_state;
        n_act     = r_act;
        n_phase   = r_phase;
        n_msg     = r_msg;
        n_k       = r_k;
        n_ce      = r_ce;
        n_exp     = r_exp;
        n_acc     = r_acc;
        n_sq      = r_sq;
        n_p       = r_p;
        n_a       = r_a;
        n_b       = r_b;
        n_cnt     = r_cnt;
        n_first   = r_first;
        n_second  = r_second;
        n_ovalid  = r_ovalid;
        n_ofirst  = r_ofirst;
        n_osecond = r_osecond;

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        if (mul_active) begin
            n_p   = mul_res;
            n_b   = {r_b[WIDTH-2:0], 1'b0};
            n_cnt = r_cnt + CNT_W'(1);
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_act    = i_in.action;
                    n_msg    = i_in.message;
                    n_k      = i_in.ephemeral_exponent;
                    n_ce     = i_in.cipher_second;
                    n_phase  = 1'b0;
                    n_first  = '0;
                    n_second = '0;
                    n_acc    = one_m;
                    n_a      = one_m;
                    n_p      = '0;
                    n_cnt    = '0;
                    n_b      = (i_in.action == emee_pkg::ACT_DECRYPT) ? i_in.cipher_first : r_g;
                    priority if (i_in.action == emee_pkg::ACT_DERIVE) begin
                        n_exp = r_priv;
                    end else if (i_in.action == emee_pkg::ACT_ENCRYPT) begin
                        n_exp = i_in.ephemeral_exponent;
                    end else begin
                        n_exp = dec_exp;
                    end
                    if (r_m == '0 || (i_in.action != emee_pkg::ACT_DERIVE &&
                                      i_in.action != emee_pkg::ACT_ENCRYPT &&
                                      i_in.action != emee_pkg::ACT_DECRYPT)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SQ_INIT;
                    end
                end
            end
            S_SQ_INIT: begin
                if (mul_done) begin
                    n_sq    = mul_res;
                    n_state = S_POW_NEXT;
                end
            end
            S_POW_NEXT: begin
                n_p   = '0;
                n_cnt = '0;
                priority if (r_exp == '0) begin
                    n_state = S_POW_END;
                end else if (r_exp[0]) begin
                    n_a     = r_acc;
                    n_b     = r_sq;
                    n_state = S_POW_MUL;
                end else begin
                    n_a     = r_sq;
                    n_b     = r_sq;
                    n_state = S_POW_SQR;
                end
            end
            S_POW_MUL: begin
                if (mul_done) begin
                    n_acc = mul_res;
                    if (r_exp[WIDTH-1:1] == '0) begin
                        n_state = S_POW_END;
                    end else begin
                        n_a     = r_sq;
                        n_b     = r_sq;
                        n_p     = '0;
                        n_cnt   = '0;
                        n_state = S_POW_SQR;
                    end
                end
            end
            S_POW_SQR: begin
                if (mul_done) begin
                    n_sq    = mul_res;
                    n_exp   = {1'b0, r_exp[WIDTH-1:1]};
                    n_state = S_POW_NEXT;
                end
            end
            S_POW_END: begin
                n_p   = '0;
                n_cnt = '0;
                n_a   = one_m;
                priority if (r_act == emee_pkg::ACT_DERIVE) begin
                    n_first = r_acc;
                    n_state = S_DONE;
                end else if (r_act == emee_pkg::ACT_ENCRYPT && !r_phase) begin
                    // second power: peer key ^ k
                    n_first = r_acc;
                    n_phase = 1'b1;
                    n_exp   = r_k;
                    n_acc   = one_m;
                    n_b     = r_peer;
                    n_state = S_SQ_INIT;
                end else if (r_act == emee_pkg::ACT_ENCRYPT) begin
                    n_b     = r_msg;
                    n_state = S_FIN_RED;
                end else begin
                    n_b     = r_ce;
                    n_state = S_FIN_RED;
                end
            end
            S_FIN_RED: begin
                if (mul_done) begin
                    n_a     = mul_res;
                    n_b     = r_acc;
                    n_p     = '0;
                    n_cnt   = '0;
                    n_state = S_FIN_MUL;
                end
            end
            S_FIN_MUL: begin
                if (mul_done) begin
                    if (r_act == emee_pkg::ACT_ENCRYPT) begin
                        n_second = mul_res;
                    end else begin
                        n_first = mul_res;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid  = 1'b1;
                    n_ofirst  = r_first;
                    n_osecond = r_second;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_m      <= WIDTH'(3);
            r_g      <= WIDTH'(2);
            r_priv   <= WIDTH'(1);
            r_peer   <= WIDTH'(1);
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    emee_pkg::REG_MODULUS:   r_m    <= i_cfg.data;
                    emee_pkg::REG_GENERATOR: r_g    <= i_cfg.data;
                    emee_pkg::REG_PRIVATE:   r_priv <= i_cfg.data;
                    emee_pkg::REG_PEER:      r_peer <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_act     <= n_act;
        r_phase   <= n_phase;
        r_msg     <= n_msg;
        r_k       <= n_k;
        r_ce      <= n_ce;
        r_exp     <= n_exp;
        r_acc     <= n_acc;
        r_sq      <= n_sq;
        r_p       <= n_p;
        r_a       <= n_a;
        r_b       <= n_b;
        r_cnt     <= n_cnt;
        r_first   <= n_first;
        r_second  <= n_second;
        r_ofirst  <= n_ofirst;
        r_osecond <= n_osecond;
    end

    // accepted word goes straight to work or to the zero answer
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_SQ_INIT || r_state == S_DONE))
        else $error("request accepted but sequencer did not start");

    // finished result reaches the output register once it is free
    a_done_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_ovalid || o_out.ready)) |=> (r_ovalid && r_state == S_IDLE))
        else $error("finished result not moved to output");

    // output valid only rises out of the done state
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_DONE))
        else $error("output valid raised outside done state");

endmodule
